>>> hw/rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, register indexes and the hue sector type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    localparam int HUE_FRAC_BITS_DEF = 6;

    localparam int          Q_W   = 9;
    localparam logic [8:0]  Q_ONE = 9'd256;

    localparam int          CFG_IDX_W      = 8;
    localparam logic [7:0]  CFG_SATURATION = 8'd0;
    localparam logic [7:0]  CFG_BRIGHTNESS = 8'd1;

    // floor(y / 15) == (y * DIV15_MUL) >> DIV15_SH for y below 3840
    localparam logic [15:0] DIV15_MUL = 16'd34953;
    localparam int          DIV15_SH  = 19;
    localparam int          SCALED_W  = 12;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

`default_nettype wire

>>> hw/rtl/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// HSV to RGB hue sector stages
// Wraps the hue modulo one circle and splits it into sector and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_sector #(
    parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [15:0]                  i_hue,
    output logic                         o_valid,
    input  wire                          i_ready,
    output hsvrgb_pkg::t_sector          o_sector,
    output logic [HUE_FRAC_BITS+5:0]     o_rem
);
    import hsvrgb_pkg::*;

    localparam int CIRCLE = 360 << HUE_FRAC_BITS;
    localparam int SECT   = 60 << HUE_FRAC_BITS;
    localparam int QMAX   = 65535 / CIRCLE;
    localparam int QUO_W  = $clog2(QMAX + 2);
    localparam int REM_W  = HUE_FRAC_BITS + 6;
    localparam logic [23:0] RECIP = 24'((64'd1 << 32) / CIRCLE);

    logic               r_s1_valid, r_s2_valid, r_s3_valid;
    logic               en_s1, en_s2, en_s3;
    logic [QUO_W-1:0]   r_s1_quot, n_s1_quot;
    logic [15:0]        r_s1_hue;
    logic [15:0]        r_s2_hw, n_s2_hw;
    t_sector            r_s3_sector, n_s3_sector;
    logic [REM_W-1:0]   r_s3_rem, n_s3_rem;
    logic [39:0]        recip_prod;
    logic [17:0]        quot_circ, diff;
    logic [17:0]        hw_ext, base;

    assign en_s3   = !r_s3_valid || i_ready;
    assign en_s2   = !r_s2_valid || en_s3;
    assign en_s1   = !r_s1_valid || en_s2;
    assign o_ready = en_s1;

    always_comb begin
        recip_prod = 40'(i_hue) * 40'(RECIP);
        n_s1_quot  = QUO_W'(recip_prod >> 32);
    end

    always_comb begin
        quot_circ = 18'(r_s1_quot) * 18'(CIRCLE);
        diff      = 18'(r_s1_hue) - quot_circ;
        if (diff >= 18'(CIRCLE)) begin
            n_s2_hw = 16'(diff - 18'(CIRCLE));
        end else begin
            n_s2_hw = 16'(diff);
        end
    end

    always_comb begin
        hw_ext = 18'(r_s2_hw);
        if (hw_ext >= 18'(5 * SECT)) begin
            n_s3_sector = SEC_MAG_RED;
            base        = 18'(5 * SECT);
        end else if (hw_ext >= 18'(4 * SECT)) begin
            n_s3_sector = SEC_BLU_MAG;
            base        = 18'(4 * SECT);
        end else if (hw_ext >= 18'(3 * SECT)) begin
            n_s3_sector = SEC_CYN_BLU;
            base        = 18'(3 * SECT);
        end else if (hw_ext >= 18'(2 * SECT)) begin
            n_s3_sector = SEC_GRN_CYN;
            base        = 18'(2 * SECT);
        end else if (hw_ext >= 18'(SECT)) begin
            n_s3_sector = SEC_YEL_GRN;
            base        = 18'(SECT);
        end else begin
            n_s3_sector = SEC_RED_YEL;
            base        = 18'd0;
        end
        n_s3_rem = REM_W'(hw_ext - base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_quot <= n_s1_quot;
            r_s1_hue  <= i_hue;
        end
        if (en_s2) begin
            r_s2_hw <= n_s2_hw;
        end
        if (en_s3) begin
            r_s3_sector <= n_s3_sector;
            r_s3_rem    <= n_s3_rem;
        end
    end

    assign o_valid  = r_s3_valid;
    assign o_sector = r_s3_sector;
    assign o_rem    = r_s3_rem;

endmodule

`default_nettype wire

>>> hw/rtl/hsvrgb_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB channel scaling stages
// Forms the v, p, q and t channel levels as truncated 8-bit values.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_scale #(
    parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  hsvrgb_pkg::t_sector          i_sector,
    input  wire  [HUE_FRAC_BITS+5:0]     i_rem,
    input  wire  [8:0]                   i_sat,
    input  wire  [8:0]                   i_bri,
    output logic                         o_valid,
    input  wire                          i_ready,
    output hsvrgb_pkg::t_sector          o_sector,
    output logic [7:0]                   o_cv,
    output logic [7:0]                   o_cp,
    output logic [7:0]                   o_cq,
    output logic [7:0]                   o_ct
);
    import hsvrgb_pkg::*;

    localparam int SECT    = 60 << HUE_FRAC_BITS;
    localparam int REM_W   = HUE_FRAC_BITS + 6;
    localparam int SR_W    = REM_W + Q_W;
    localparam int N_W     = HUE_FRAC_BITS + 14;
    localparam int X_W     = N_W + 16;
    localparam int X_SH    = HUE_FRAC_BITS + 18;
    localparam int DIVP_W  = SCALED_W + 16;

    logic                 r_s4_valid, r_s5_valid, r_s6_valid;
    logic                 en_s4, en_s5, en_s6;
    t_sector              r_s4_sector, r_s5_sector, r_s6_sector;
    logic [SR_W-1:0]      r_s4_sq, r_s4_st, n_s4_sq, n_s4_st;
    logic [SCALED_W-1:0]  r_s5_yq, r_s5_yt, n_s5_yq, n_s5_yt;
    logic [7:0]           r_s5_cv, r_s5_cp, n_s5_cv, n_s5_cp;
    logic [7:0]           r_s6_cv, r_s6_cp, r_s6_cq, r_s6_ct, n_s6_cq, n_s6_ct;
    logic [16:0]          bri_255;
    logic [15:0]          amp;
    logic [N_W-1:0]       mq, mt;
    logic [X_W-1:0]       xq, xt;
    logic [24:0]          xp;
    logic [DIVP_W-1:0]    dq, dt;

    assign en_s6   = !r_s6_valid || i_ready;
    assign en_s5   = !r_s5_valid || en_s6;
    assign en_s4   = !r_s4_valid || en_s5;
    assign o_ready = en_s4;

    always_comb begin
        n_s4_sq = SR_W'(i_sat) * SR_W'(i_rem);
        n_s4_st = SR_W'(i_sat) * SR_W'(REM_W'(SECT) - i_rem);
    end

    always_comb begin
        bri_255 = (17'(i_bri) << 8) - 17'(i_bri);
        amp     = 16'(bri_255);
        mq      = N_W'(256 * SECT) - N_W'(r_s4_sq);
        mt      = N_W'(256 * SECT) - N_W'(r_s4_st);
        xq      = X_W'(amp) * X_W'(mq);
        xt      = X_W'(amp) * X_W'(mt);
        xp      = 25'(amp) * 25'(Q_ONE - i_sat);
        n_s5_yq = SCALED_W'(xq >> X_SH);
        n_s5_yt = SCALED_W'(xt >> X_SH);
        n_s5_cp = xp[23:16];
        n_s5_cv = amp[15:8];
    end

    always_comb begin
        dq      = DIVP_W'(r_s5_yq) * DIVP_W'(DIV15_MUL);
        dt      = DIVP_W'(r_s5_yt) * DIVP_W'(DIV15_MUL);
        n_s6_cq = 8'(dq >> DIV15_SH);
        n_s6_ct = 8'(dt >> DIV15_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else begin
            if (en_s4) begin
                r_s4_valid <= i_valid;
            end
            if (en_s5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (en_s6) begin
                r_s6_valid <= r_s5_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s4) begin
            r_s4_sector <= i_sector;
            r_s4_sq     <= n_s4_sq;
            r_s4_st     <= n_s4_st;
        end
        if (en_s5) begin
            r_s5_sector <= r_s4_sector;
            r_s5_yq     <= n_s5_yq;
            r_s5_yt     <= n_s5_yt;
            r_s5_cv     <= n_s5_cv;
            r_s5_cp     <= n_s5_cp;
        end
        if (en_s6) begin
            r_s6_sector <= r_s5_sector;
            r_s6_cv     <= r_s5_cv;
            r_s6_cp     <= r_s5_cp;
            r_s6_cq     <= n_s6_cq;
            r_s6_ct     <= n_s6_ct;
        end
    end

    assign o_valid  = r_s6_valid;
    assign o_sector = r_s6_sector;
    assign o_cv     = r_s6_cv;
    assign o_cp     = r_s6_cp;
    assign o_cq     = r_s6_cq;
    assign o_ct     = r_s6_ct;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a stream of hue angles to 8-bit RGB pixels and a packed GRB word.
//
// Input stream s_axis carries one hue per transfer, in 1/2^HUE_FRAC_BITS
// degree units; any 16-bit value is wrapped modulo a full circle.
// Output stream m_axis carries red, green, blue and the GRB word of the pixel.
// Saturation and brightness (Q1.8, 256 = 1.0, larger values act as 256) are
// written through the cfg channel, index 0 and 1; the user must write them
// only while the stream is idle, as the block does not enforce it. The cfg
// channel is always ready. A pixel passes three hue stages (wrap, correct,
// sector), three scaling stages (sector multiply, channel multiply, divide
// by 15) and the output register.
// One pixel per cycle unless m_axis stalls; each stage holds its own valid bit.
// When m_axis stalls the stages fill up and bubbles close, s_axis_tready
// falls only once every stage holds a pixel; nothing is lost or repeated.
// Reset clears all valid bits and sets both registers to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter #(
    parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [15:0]                           s_axis_tdata,   // hue
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [47:0]                           m_axis_tdata,   // red, green, blue, grb_word
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [hsvrgb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [hsvrgb_pkg::Q_W-1:0]            i_cfg_data
);
    import hsvrgb_pkg::*;

    localparam int REM_W = HUE_FRAC_BITS + 6;

    logic [Q_W-1:0]     r_sat, r_bri;
    logic [Q_W-1:0]     sat_clamp, bri_clamp;
    logic               sec_valid, sec_ready;
    t_sector            sec_sector;
    logic [REM_W-1:0]   sec_rem;
    logic               scl_valid, scl_ready;
    t_sector            scl_sector;
    logic [7:0]         scl_cv, scl_cp, scl_cq, scl_ct;
    logic               en_out;
    logic               r_out_valid;
    logic [7:0]         r_red, r_green, r_blue, n_red, n_green, n_blue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= Q_ONE;
            r_bri <= Q_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SATURATION: r_sat <= i_cfg_data;
                CFG_BRIGHTNESS: r_bri <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sat_clamp = (r_sat > Q_ONE) ? Q_ONE : r_sat;
    assign bri_clamp = (r_bri > Q_ONE) ? Q_ONE : r_bri;

    hsvrgb_sector #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_sector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_hue    (s_axis_tdata),
        .o_valid  (sec_valid),
        .i_ready  (sec_ready),
        .o_sector (sec_sector),
        .o_rem    (sec_rem)
    );

    hsvrgb_scale #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sec_valid),
        .o_ready  (sec_ready),
        .i_sector (sec_sector),
        .i_rem    (sec_rem),
        .i_sat    (sat_clamp),
        .i_bri    (bri_clamp),
        .o_valid  (scl_valid),
        .i_ready  (scl_ready),
        .o_sector (scl_sector),
        .o_cv     (scl_cv),
        .o_cp     (scl_cp),
        .o_cq     (scl_cq),
        .o_ct     (scl_ct)
    );

    assign en_out    = !r_out_valid || m_axis_tready;
    assign scl_ready = en_out;

    always_comb begin
        case (scl_sector)
            SEC_RED_YEL: begin n_red = scl_cv; n_green = scl_ct; n_blue = scl_cp; end
            SEC_YEL_GRN: begin n_red = scl_cq; n_green = scl_cv; n_blue = scl_cp; end
            SEC_GRN_CYN: begin n_red = scl_cp; n_green = scl_cv; n_blue = scl_ct; end
            SEC_CYN_BLU: begin n_red = scl_cp; n_green = scl_cq; n_blue = scl_cv; end
            SEC_BLU_MAG: begin n_red = scl_ct; n_green = scl_cp; n_blue = scl_cv; end
            default:     begin n_red = scl_cv; n_green = scl_cp; n_blue = scl_cq; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= scl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_green, r_red, r_blue, r_blue, r_green, r_red};

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    a_grb_packing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:40] == m_axis_tdata[15:8])
                       && (m_axis_tdata[39:32] == m_axis_tdata[7:0])
                       && (m_axis_tdata[31:24] == m_axis_tdata[23:16]))
        else $error("grb word does not match channels");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

>>> tb/rgb_pixel_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB pixel checker
// Watches the hue, pixel and register channels of the converter. Tracks the
// saturation and brightness registers, predicts each pixel from the accepted
// hue in exact integer arithmetic, and compares every output transfer
// against the oldest predicted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_pixel_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [15:0] i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [47:0] i_m_tdata,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [8:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    import hsvrgb_pkg::*;

    localparam int unsigned SECTOR_UNITS = 60 << HUE_FRAC_BITS_DEF;
    localparam int unsigned CIRCLE_UNITS = 360 << HUE_FRAC_BITS_DEF;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] grb_word;
    } t_rgb_pixel;

    t_rgb_pixel pending_pixels[$];
    logic [8:0] sat_level = Q_ONE;
    logic [8:0] val_level = Q_ONE;

    function automatic logic [7:0] scale_level(longint unsigned v, longint unsigned m);
        longint unsigned quotient;
        quotient = (longint'(255) * v * m) / (longint'(65536) * SECTOR_UNITS);
        return (quotient > 255) ? 8'd255 : quotient[7:0];
    endfunction

    function automatic t_rgb_pixel hsv_pixel(logic [15:0] hue, logic [8:0] sat_q,
                                             logic [8:0] val_q);
        longint unsigned wrapped;
        longint unsigned offset;
        longint unsigned s;
        longint unsigned v;
        longint unsigned full;
        logic [2:0]      sector;
        logic [7:0]      lv, lp, lq, lt;
        t_rgb_pixel      px;
        wrapped = longint'(hue) % CIRCLE_UNITS;
        sector  = 3'(wrapped / SECTOR_UNITS);
        offset  = wrapped % SECTOR_UNITS;
        s       = (sat_q > Q_ONE) ? longint'(Q_ONE) : longint'(sat_q);
        v       = (val_q > Q_ONE) ? longint'(Q_ONE) : longint'(val_q);
        full    = longint'(Q_ONE) * SECTOR_UNITS;
        lv = scale_level(v, full);
        lp = scale_level(v, (longint'(Q_ONE) - s) * SECTOR_UNITS);
        lq = scale_level(v, full - s * offset);
        lt = scale_level(v, full - s * (SECTOR_UNITS - offset));
        case (sector)
            SEC_RED_YEL: begin px.red = lv; px.green = lt; px.blue = lp; end
            SEC_YEL_GRN: begin px.red = lq; px.green = lv; px.blue = lp; end
            SEC_GRN_CYN: begin px.red = lp; px.green = lv; px.blue = lt; end
            SEC_CYN_BLU: begin px.red = lp; px.green = lq; px.blue = lv; end
            SEC_BLU_MAG: begin px.red = lt; px.green = lp; px.blue = lv; end
            default:     begin px.red = lv; px.green = lp; px.blue = lq; end
        endcase
        px.grb_word = {px.green, px.red, px.blue};
        return px;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (!i_rst_n) begin
            sat_level = Q_ONE;
            val_level = Q_ONE;
            o_fail_count = 0;
            pending_pixels.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel transfer with no pixel pending: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("red", want.red, i_m_tdata[7:0]);
                    check_field("green", want.green, i_m_tdata[15:8]);
                    check_field("blue", want.blue, i_m_tdata[23:16]);
                    check_field("grb_word", want.grb_word, i_m_tdata[47:24]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_pixels.push_back(hsv_pixel(i_s_tdata, sat_level, val_level));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SATURATION: sat_level = i_cfg_data;
                    CFG_BRIGHTNESS: val_level = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives hue transfers in random bursts through a series of saturation and
// brightness settings, extremes and out-of-range values included, while the
// pixel side stalls on its own pattern with one long hold-off. The checker
// predicts and compares every pixel; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import hsvrgb_pkg::*;

    localparam int SECTOR_UNITS    = 60 << HUE_FRAC_BITS_DEF;
    localparam int CIRCLE_UNITS    = 360 << HUE_FRAC_BITS_DEF;
    localparam int PIPE_LATENCY    = 7;
    localparam int RANDOM_PHASES   = 9;
    localparam int HUES_PER_PHASE  = 140;
    localparam int LONG_HOLD       = 120;
    localparam int RUN_LIMIT       = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index   = '0;
    logic [8:0]  i_cfg_data    = '0;

    int   fail_count;
    int   pixels_pending;
    int   cycle_count   = 0;
    int   burst_left    = 0;
    logic long_hold_req = 1'b0;

    logic [15:0] edge_hues [20] = '{
        16'd0, 16'd1, 16'd63, 16'd3839, 16'd3840, 16'd3841, 16'd7679, 16'd7680,
        16'd11520, 16'd15359, 16'd15360, 16'd19200, 16'd21119, 16'd23039,
        16'd23040, 16'd23041, 16'd46080, 16'd65535, 16'h5555, 16'hAAAA
    };

    hsv_to_rgb_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rgb_pixel_checker pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pixels_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // pixel side: stall pattern in spans, one long hold-off on request
    initial begin
        int mode;
        int span;
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [15:0] pick_hue();
        int k;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, CIRCLE_UNITS - 1));
            2: begin
                k = $urandom_range(0, 17);
                return 16'(k * SECTOR_UNITS + $urandom_range(0, 2) - 1);
            end
            default: return 16'($urandom_range(CIRCLE_UNITS, 65535));
        endcase
    endfunction

    task automatic send_hue(input logic [15:0] hue);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= hue;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end else begin
            burst_left--;
        end
    endtask

    // hold until every pixel is out and the pipeline has emptied
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pixels_pending != 0);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [8:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_levels(input logic [8:0] sat, input logic [8:0] bri,
                              input logic [7:0] stray_index);
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_BRIGHTNESS, bri);
        write_reg(stray_index, 9'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [8:0] sat;
        logic [8:0] bri;
        logic [7:0] stray;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_hues[n])
            send_hue(edge_hues[n]);
        drain_stream();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin sat = 9'd0;   bri = 9'd256; end
                1: begin sat = 9'd256; bri = 9'd0;   end
                2: begin sat = 9'd511; bri = 9'd511; end
                3: begin sat = 9'd257; bri = 9'd1;   end
                4: begin sat = 9'd1;   bri = 9'd255; end
                5: begin sat = 9'd255; bri = 9'd257; end
                default: begin
                    sat = ($urandom_range(0, 3) == 0) ? Q_ONE : 9'($urandom);
                    bri = ($urandom_range(0, 3) == 0) ? Q_ONE : 9'($urandom);
                end
            endcase
            stray = (phase == 2) ? 8'hFF : 8'($urandom_range(2, 255));
            set_levels(sat, bri, stray);
            if (phase == 0)
                long_hold_req = 1'b1;
            repeat (HUES_PER_PHASE)
                send_hue(pick_hue());
            drain_stream();
        end

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_sector.sv
hw/rtl/hsvrgb_scale.sv
hw/rtl/hsv_to_rgb_converter.sv
tb/rgb_pixel_checker.sv
tb/testbench.sv
